>>> rtl/dife_pkg.sv
// Package with the shared types, constants and character codes of the field extractor.
package dife_pkg;

  localparam int MAX_FIELDS_DEF = 32;
  localparam int QUEUE_DEPTH    = 4;
  localparam int MASK_W         = 32;
  localparam int VALUE_W        = 32;
  localparam int FNUM_W         = 5;
  localparam int COUNT_W        = 6;
  localparam int CFG_IDX_W      = 1;

  localparam logic [CFG_IDX_W-1:0] REG_DELIMITER  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIELD_MASK = 1'd1;

  localparam logic [7:0]        DELIMITER_RST  = 8'd44;
  localparam logic [MASK_W-1:0] FIELD_MASK_RST = 32'd1;

  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_9     = 8'h39;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;

  localparam logic KIND_VALUE   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam logic [VALUE_W-1:0] MAG_LIMIT = 32'h8000_0000;
  localparam logic [VALUE_W-1:0] POS_MAX   = 32'h7FFF_FFFF;

  typedef enum logic [1:0] {
    PH_SPACE  = 2'd0,
    PH_DIGITS = 2'd1,
    PH_DONE   = 2'd2
  } phase_t;

  // One queue entry: the results caused by one byte.
  typedef struct packed {
    logic                     val_vld;
    logic signed [VALUE_W-1:0] value;
    logic [FNUM_W-1:0]        fnum;
    logic [COUNT_W-1:0]       cnt;
    logic                     sum_vld;
    logic                     halted;
  } evt_t;

endpackage

>>> rtl/dife_front.sv
// Front end: takes bytes, tracks fields, parses integers and produces result entries.
module dife_front import dife_pkg::*; #(
  parameter int MAX_FIELDS = MAX_FIELDS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [MASK_W-1:0]    cfg_data,
  input  logic                 accept,
  input  logic [7:0]           data_byte,
  input  logic                 end_of_record,
  output logic                 push,
  output evt_t                 evt
);

  localparam int FIDX_W = $clog2(MAX_FIELDS + 1);

  logic [7:0]         delimiter_r;
  logic [MASK_W-1:0]  field_mask_r;
  logic [FIDX_W-1:0]  field_index_r, field_index_nxt;
  logic [VALUE_W-1:0] acc_r, acc_nxt;
  logic               neg_r, neg_nxt;
  phase_t             phase_r, phase_nxt;
  logic               fcd_r, fcd_nxt;
  logic               fcs_r, fcs_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic               halted_r, halted_nxt;

  logic               is_delim, is_digit, is_space, is_sign;
  logic               sel, emit;
  logic [VALUE_W+3:0] acc_sum;
  logic [VALUE_W-1:0] acc_dig;
  logic [VALUE_W-1:0] fval;

  assign is_delim = (data_byte == delimiter_r);
  assign is_digit = data_byte inside {[CHAR_0:CHAR_9]};
  assign is_space = data_byte inside {CHAR_SPACE, [CHAR_TAB:CHAR_CR]};
  assign is_sign  = (data_byte == CHAR_PLUS) || (data_byte == CHAR_MINUS);

  assign acc_sum = {1'b0, acc_r, 3'b0} + {3'b0, acc_r, 1'b0}
                   + {28'b0, data_byte - CHAR_0};
  assign acc_dig = (acc_sum > {4'b0, MAG_LIMIT}) ? MAG_LIMIT : acc_sum[VALUE_W-1:0];

  assign fval = neg_r ? (~acc_r + 32'd1) : (acc_r[VALUE_W-1] ? POS_MAX : acc_r);

  assign sel  = !halted_r && (int'(field_index_r) < MASK_W)
                && field_mask_r[FNUM_W'(field_index_r)];
  assign emit = is_delim && sel && !((acc_r == '0) && !fcd_r);

  // Parse phase sequencing.
  always_comb begin
    phase_nxt = phase_r;
    if (accept) begin
      if (is_delim || end_of_record) begin
        phase_nxt = PH_SPACE;
      end else begin
        case (phase_r)
          PH_SPACE: begin
            if (is_sign || is_digit) begin
              phase_nxt = PH_DIGITS;
            end else if (!is_space) begin
              phase_nxt = PH_DONE;
            end
          end
          PH_DIGITS: begin
            if (!is_digit) begin
              phase_nxt = PH_DONE;
            end
          end
          default: phase_nxt = phase_r;
        endcase
      end
    end
  end

  always_comb begin
    field_index_nxt = field_index_r;
    acc_nxt         = acc_r;
    neg_nxt         = neg_r;
    fcd_nxt         = fcd_r;
    fcs_nxt         = fcs_r;
    count_nxt       = count_r;
    halted_nxt      = halted_r;
    if (accept) begin
      if (is_delim) begin
        if (sel && !emit) begin
          halted_nxt = 1'b1;
        end
        if (emit) begin
          count_nxt = count_r + COUNT_W'(1);
        end
        if (int'(field_index_r) < MAX_FIELDS) begin
          field_index_nxt = field_index_r + FIDX_W'(1);
        end
        acc_nxt = '0;
        neg_nxt = 1'b0;
        fcd_nxt = 1'b0;
        fcs_nxt = 1'b0;
      end else begin
        if (!fcs_r) begin
          fcs_nxt = 1'b1;
          fcd_nxt = is_digit;
        end
        if (phase_r == PH_SPACE) begin
          if (is_sign) begin
            neg_nxt = (data_byte == CHAR_MINUS);
          end else if (is_digit && !is_space) begin
            acc_nxt = acc_dig;
          end
        end else if (phase_r == PH_DIGITS && is_digit) begin
          acc_nxt = acc_dig;
        end
      end
    end
  end

  always_comb begin
    push        = accept && (emit || end_of_record);
    evt.val_vld = emit;
    evt.value   = fval;
    evt.fnum    = FNUM_W'(field_index_r);
    evt.cnt     = count_nxt;
    evt.sum_vld = end_of_record;
    evt.halted  = halted_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delimiter_r  <= DELIMITER_RST;
      field_mask_r <= FIELD_MASK_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DELIMITER:  delimiter_r  <= cfg_data[7:0];
        REG_FIELD_MASK: field_mask_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (accept && end_of_record)) begin
      field_index_r <= '0;
      acc_r         <= '0;
      neg_r         <= 1'b0;
      phase_r       <= PH_SPACE;
      fcd_r         <= 1'b0;
      fcs_r         <= 1'b0;
      count_r       <= '0;
      halted_r      <= 1'b0;
    end else begin
      field_index_r <= field_index_nxt;
      acc_r         <= acc_nxt;
      neg_r         <= neg_nxt;
      phase_r       <= phase_nxt;
      fcd_r         <= fcd_nxt;
      fcs_r         <= fcs_nxt;
      count_r       <= count_nxt;
      halted_r      <= halted_nxt;
    end
  end

endmodule

>>> rtl/dife_fifo.sv
// Short queue of result entries between the front end and the output stage.
module dife_fifo import dife_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  evt_t push_evt,
  input  logic pop,
  output logic full,
  output logic not_empty,
  output evt_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  evt_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] fill_r;
  logic             do_pop;

  assign full      = (int'(fill_r) == DEPTH);
  assign not_empty = (fill_r != '0);
  assign head      = mem[rd_ptr_r];
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_evt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (int'(wr_ptr_r) == DEPTH - 1) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (int'(rd_ptr_r) == DEPTH - 1) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      fill_r <= fill_r + CNT_W'(push) - CNT_W'(do_pop);
    end
  end

endmodule

>>> rtl/dife_back.sv
// Output stage: unpacks queue entries into result beats held in an output register.
module dife_back import dife_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_vld,
  input  evt_t                      head,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_kind,
  output logic signed [VALUE_W-1:0] out_value,
  output logic [FNUM_W-1:0]         out_field_number,
  output logic [COUNT_W-1:0]        out_value_count,
  output logic                      out_stopped_early,
  output logic                      out_last
);

  logic                      valid_r;
  logic                      sent_val_r, sent_val_nxt;
  logic                      kind_r;
  logic signed [VALUE_W-1:0] value_r;
  logic [FNUM_W-1:0]         fnum_r;
  logic [COUNT_W-1:0]        cnt_r;
  logic                      stop_r;
  logic                      last_r;
  logic                      load, take_value;

  assign load       = q_vld && (!valid_r || !out_stall);
  assign take_value = head.val_vld && !sent_val_r;
  assign pop        = load && !(take_value && head.sum_vld);

  always_comb begin
    sent_val_nxt = sent_val_r;
    if (load) begin
      sent_val_nxt = take_value && head.sum_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= 1'b0;
      sent_val_r <= 1'b0;
    end else begin
      sent_val_r <= sent_val_nxt;
      if (load) begin
        valid_r <= 1'b1;
      end else if (!out_stall) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (take_value) begin
        kind_r  <= KIND_VALUE;
        value_r <= head.value;
        fnum_r  <= head.fnum;
        stop_r  <= 1'b0;
        last_r  <= !head.sum_vld;
      end else begin
        kind_r  <= KIND_SUMMARY;
        value_r <= '0;
        fnum_r  <= '0;
        stop_r  <= head.halted;
        last_r  <= 1'b1;
      end
      cnt_r <= head.cnt;
    end
  end

  assign out_valid         = valid_r;
  assign out_kind          = kind_r;
  assign out_value         = value_r;
  assign out_field_number  = fnum_r;
  assign out_value_count   = cnt_r;
  assign out_stopped_early = stop_r;
  assign out_last          = last_r;

endmodule

>>> rtl/delimited_int_field_extractor.sv
// Top level of the delimited integer field extractor.
// The block takes one byte per clock cycle whenever its four-entry result queue has room, so
// a stream of bytes runs at one byte per cycle while the queue has room. Results leave through
// an output register at one beat per cycle while out_stall is low; a delimiter byte that
// also ends the record gives two beats (the field value, then the record summary), which the
// queue absorbs. With an empty queue, a result is written into the queue when its byte is
// accepted and then into the output register; queued results and output stalls delay it.
module delimited_int_field_extractor import dife_pkg::*; #(
  parameter int MAX_FIELDS = MAX_FIELDS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [MASK_W-1:0]         cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [7:0]                in_data_byte,
  input  logic                      in_end_of_record,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_kind,
  output logic signed [VALUE_W-1:0] out_value,
  output logic [FNUM_W-1:0]         out_field_number,
  output logic [COUNT_W-1:0]        out_value_count,
  output logic                      out_stopped_early,
  output logic                      out_last
);

  logic accept, push, full, q_vld, pop;
  evt_t push_evt, head;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  dife_front #(.MAX_FIELDS(MAX_FIELDS)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .accept        (accept),
    .data_byte     (in_data_byte),
    .end_of_record (in_end_of_record),
    .push          (push),
    .evt           (push_evt)
  );

  dife_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_evt  (push_evt),
    .pop       (pop),
    .full      (full),
    .not_empty (q_vld),
    .head      (head)
  );

  dife_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_vld             (q_vld),
    .head              (head),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_value         (out_value),
    .out_field_number  (out_field_number),
    .out_value_count   (out_value_count),
    .out_stopped_early (out_stopped_early),
    .out_last          (out_last)
  );

endmodule
